[hdl/ldwg_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the LED dimming waveform generator.
package ldwg_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int SINE_POINTS = 256;
    localparam int SINE_BITS   = $clog2(SINE_POINTS);
    localparam int PERMILLE_W  = 10;
    localparam int TAB_W       = 25;
    localparam int ACC_W       = PERMILLE_W + 16;
    localparam int TRI_W       = 11;
    localparam int SINE_DIVD_W = COUNT_WIDTH + SINE_BITS + 2;
    localparam int TRI_DIVD_W  = COUNT_WIDTH + TRI_W;
    localparam int DIV_W       = (SINE_DIVD_W > TRI_DIVD_W) ? SINE_DIVD_W : TRI_DIVD_W;
    localparam int DVS_W       = (COUNT_WIDTH > PERMILLE_W) ? COUNT_WIDTH : PERMILLE_W;
    localparam int SCALE_W     = 2 * PERMILLE_W;
    localparam int ITER_W      = $clog2(DIV_W + 1);

    localparam logic [PERMILLE_W-1:0] PERMILLE_FULL = PERMILLE_W'(1000);
    localparam logic [TRI_W-1:0]      TRI_SCALE     = TRI_W'(2000);
    localparam logic [ACC_W-1:0]      SINE_BASE     = ACC_W'(500) << 16;
    localparam logic [ACC_W-1:0]      SINE_ROUND    = ACC_W'(65535);

    localparam logic [2:0] MODE_OFF      = 3'd0;
    localparam logic [2:0] MODE_ON       = 3'd1;
    localparam logic [2:0] MODE_BLINK    = 3'd2;
    localparam logic [2:0] MODE_SINE     = 3'd3;
    localparam logic [2:0] MODE_TRIANGLE = 3'd4;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_MIN       = 3'd1;
    localparam logic [2:0] REG_MAX       = 3'd2;
    localparam logic [2:0] REG_BLINK_ON  = 3'd3;
    localparam logic [2:0] REG_BLINK_OFF = 3'd4;
    localparam logic [2:0] REG_PERIOD    = 3'd5;
    localparam logic [2:0] REG_START     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_VLOAD,
        ST_VDIV,
        ST_PROD,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef logic [TAB_W-1:0] sine_tab_t [SINE_POINTS+1];

    // Odd Q30 polynomial to degree nine, scaled to 500 * sin in Q16.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        for (int k = 0; k <= SINE_POINTS; k++)
        begin
            t  = (64'(k) << 30) / 64'(SINE_POINTS);
            t2 = (t * t) >> 30;
            p  = 64'd172273;
            p  = 64'd5026995 - ((t2 * p) >> 30);
            p  = 64'd85569306 - ((t2 * p) >> 30);
            p  = 64'd693598668 - ((t2 * p) >> 30);
            p  = 64'd1686629713 - ((t2 * p) >> 30);
            s  = (t * p) >> 30;
            if (s > (64'd1 << 30))
            begin
                s = 64'd1 << 30;
            end
            tab[k] = TAB_W'((s * 64'd500) >> 14);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[hdl/led_dim_waveform_generator.sv]
// Top level of the LED dimming waveform generator with its serial divider datapath.
//
// Channel  Dir  Contents
// s_axis   in   tdata[0] tick, tdata[7:1] zero
// m_axis   out  tdata[0] pwm_enable, tdata[10:1] duty_permille, tdata[15:11] zero
// cfg      in   cfg_index register number 0..6, cfg_data register value
//
// Off, on and blink modes, and wave modes without a tick, go from idle to the emit state.
// A wave tick runs the value division and the scaling division, with the value division
// skipped for a triangle at index zero and a modulo division first when the index is not
// below the period; the restoring divider retires one quotient bit per cycle.
// Reset loads the register defaults at once; there is no clearing pass.
// A result waiting on m_axis holds only the final stage; the next item is accepted
// as soon as the previous one has been handed to the output register, unless a cfg write waits.
module led_dim_waveform_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] pwm_enable, [10:1] duty_permille
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ldwg_pkg::*;

    localparam int CNT_W = COUNT_WIDTH;

    logic [2:0]             mode_reg, mode_next;
    logic [PERMILLE_W-1:0]  min_reg, min_next;
    logic [PERMILLE_W-1:0]  max_reg, max_next;
    logic [15:0]            on_reg, on_next;
    logic [15:0]            off_reg, off_next;
    logic [15:0]            period_reg, period_next;
    logic [15:0]            start_reg, start_next;

    logic [CNT_W-1:0]       step_reg, step_next;
    logic                   phase_on_reg, phase_on_next;
    logic [CNT_W-1:0]       blink_cnt_reg, blink_cnt_next;
    logic                   wave_valid_reg, wave_valid_next;
    logic [PERMILLE_W-1:0]  wave_duty_reg, wave_duty_next;

    state_t                 state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;

    logic [CNT_W-1:0]       p_reg, p_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [PERMILLE_W-1:0]  val_reg, val_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [DVS_W-1:0]       rem_reg, rem_next;
    logic [DVS_W-1:0]       dvs_reg, dvs_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   pend_en_reg, pend_en_next;
    logic [PERMILLE_W-1:0]  pend_duty_reg, pend_duty_next;
    logic                   m_en_reg, m_en_next;
    logic [PERMILLE_W-1:0]  m_duty_reg, m_duty_next;

    logic [PERMILLE_W-1:0]  eff_max;
    logic [PERMILLE_W-1:0]  eff_min;
    logic [PERMILLE_W-1:0]  span;
    logic [CNT_W-1:0]       eff_period;
    logic [CNT_W-1:0]       start_cnt;
    logic [CNT_W-1:0]       on_len;
    logic [CNT_W-1:0]       off_len;
    logic [CNT_W-1:0]       cfg_cnt;
    logic [CNT_W-1:0]       blink_inc;
    logic [CNT_W-1:0]       blink_len;

    logic [DVS_W:0]         rem_shift;
    logic                   q_bit;
    logic [DVS_W-1:0]       rem_step;
    logic [DIV_W-1:0]       quo_step;
    logic                   div_busy;

    logic [SINE_BITS+1:0]   sine_q;
    logic [SINE_BITS:0]     tab_idx;
    logic [ACC_W-1:0]       tab_val;
    logic [ACC_W-1:0]       sine_acc;
    logic [ACC_W-1:0]       sine_round;
    logic [PERMILLE_W-1:0]  sine_val;
    logic [PERMILLE_W-1:0]  tri_val;
    logic [CNT_W-1:0]       tri_arg;
    logic [DIV_W-1:0]       tri_prod;
    logic [SCALE_W-1:0]     scale_prod;
    logic [CNT_W:0]         idx_inc;
    logic [PERMILLE_W-1:0]  scaled_duty;

    logic                   in_fire;
    logic                   cfg_fire;
    logic                   out_free;
    logic                   is_wave;
    logic                   tick;

    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_duty_reg, m_en_reg};

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign tick     = s_axis_tdata[0];
    assign is_wave  = (mode_reg == MODE_SINE) || (mode_reg == MODE_TRIANGLE);

    assign eff_max    = (max_reg > PERMILLE_FULL) ? PERMILLE_FULL : max_reg;
    assign eff_min    = (min_reg > eff_max) ? eff_max : min_reg;
    assign span       = eff_max - eff_min;
    assign eff_period = (CNT_W'(period_reg) == '0) ? CNT_W'(1) : CNT_W'(period_reg);
    assign start_cnt  = CNT_W'(start_reg);
    assign on_len     = CNT_W'(on_reg);
    assign off_len    = CNT_W'(off_reg);
    assign cfg_cnt    = CNT_W'(cfg_data);
    assign blink_inc  = blink_cnt_reg + CNT_W'(1);
    assign blink_len  = phase_on_reg ? on_len : off_len;

    // One restoring step: shift in the next dividend bit and try the divisor.
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign q_bit     = rem_shift >= {1'b0, dvs_reg};
    assign rem_step  = q_bit ? DVS_W'(rem_shift - {1'b0, dvs_reg}) : DVS_W'(rem_shift);
    assign quo_step  = {quo_reg[DIV_W-2:0], q_bit};
    assign div_busy  = (iter_reg != '0);

    assign sine_q     = quo_reg[SINE_BITS+1:0];
    assign tab_idx    = sine_q[SINE_BITS] ?
                        ((SINE_BITS+1)'(SINE_POINTS) - {1'b0, sine_q[SINE_BITS-1:0]}) :
                        {1'b0, sine_q[SINE_BITS-1:0]};
    assign tab_val    = ACC_W'(SINE_TAB[tab_idx]);
    assign sine_acc   = sine_q[SINE_BITS+1] ? (SINE_BASE - tab_val) : (SINE_BASE + tab_val);
    assign sine_round = sine_acc + SINE_ROUND;
    assign sine_val   = sine_round[ACC_W-1:16];
    assign tri_val    = (quo_reg > DIV_W'(PERMILLE_FULL)) ? PERMILLE_FULL :
                        quo_reg[PERMILLE_W-1:0];

    assign tri_arg     = (idx_reg < (p_reg >> 1)) ? idx_reg : (p_reg - idx_reg);
    assign tri_prod    = DIV_W'(tri_arg) * DIV_W'(TRI_SCALE);
    assign scale_prod  = SCALE_W'(span) * SCALE_W'(val_reg);
    assign idx_inc     = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign scaled_duty = eff_min + quo_reg[PERMILLE_W-1:0];

    always_comb
    begin
        mode_next       = mode_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        on_next         = on_reg;
        off_next        = off_reg;
        period_next     = period_reg;
        start_next      = start_reg;
        step_next       = step_reg;
        phase_on_next   = phase_on_reg;
        blink_cnt_next  = blink_cnt_reg;
        wave_valid_next = wave_valid_reg;
        wave_duty_next  = wave_duty_reg;
        state_next      = state_reg;
        p_next          = p_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        iter_next       = iter_reg;
        pend_en_next    = pend_en_reg;
        pend_duty_next  = pend_duty_reg;
        m_en_next       = m_en_reg;
        m_duty_next     = m_duty_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    unique case (cfg_index)
                        REG_MODE:
                        begin
                            mode_next = cfg_data[2:0];
                            if (cfg_data[2:0] != mode_reg)
                            begin
                                step_next       = (start_cnt < eff_period) ? start_cnt : '0;
                                phase_on_next   = 1'b1;
                                blink_cnt_next  = '0;
                                wave_valid_next = 1'b0;
                            end
                        end
                        REG_MIN:       min_next    = cfg_data[PERMILLE_W-1:0];
                        REG_MAX:       max_next    = cfg_data[PERMILLE_W-1:0];
                        REG_BLINK_ON:  on_next     = cfg_data;
                        REG_BLINK_OFF: off_next    = cfg_data;
                        REG_PERIOD:    period_next = cfg_data;
                        REG_START:
                        begin
                            start_next = cfg_data;
                            if (cfg_cnt < eff_period)
                            begin
                                step_next = cfg_cnt;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (in_fire)
                begin
                    state_next     = ST_EMIT;
                    pend_en_next   = 1'b0;
                    pend_duty_next = '0;
                    priority if (mode_reg == MODE_ON)
                    begin
                        pend_en_next   = 1'b1;
                        pend_duty_next = eff_max;
                    end
                    else if (mode_reg == MODE_BLINK)
                    begin
                        if (on_len == '0)
                        begin
                            pend_en_next = 1'b0;
                        end
                        else if (off_len == '0)
                        begin
                            pend_en_next   = 1'b1;
                            pend_duty_next = eff_max;
                        end
                        else
                        begin
                            pend_en_next   = phase_on_reg;
                            pend_duty_next = phase_on_reg ? eff_max : '0;
                            if (tick)
                            begin
                                blink_cnt_next = blink_inc;
                                if (blink_inc >= blink_len)
                                begin
                                    phase_on_next  = !phase_on_reg;
                                    blink_cnt_next = '0;
                                    pend_en_next   = !phase_on_reg;
                                    pend_duty_next = phase_on_reg ? '0 : eff_max;
                                end
                            end
                        end
                    end
                    else if (is_wave)
                    begin
                        pend_en_next   = 1'b1;
                        pend_duty_next = wave_valid_reg ? wave_duty_reg : eff_max;
                        if (tick)
                        begin
                            p_next = eff_period;
                            if (step_reg < eff_period)
                            begin
                                idx_next   = step_reg;
                                state_next = ST_VLOAD;
                            end
                            else
                            begin
                                quo_next   = {step_reg, {(DIV_W-CNT_W){1'b0}}};
                                rem_next   = '0;
                                dvs_next   = DVS_W'(eff_period);
                                iter_next  = ITER_W'(CNT_W);
                                state_next = ST_MOD;
                            end
                        end
                    end
                    else
                    begin
                        pend_en_next = 1'b0;
                    end
                end
            end

            ST_MOD:
            begin
                if (div_busy)
                begin
                    quo_next  = quo_step;
                    rem_next  = rem_step;
                    iter_next = iter_reg - ITER_W'(1);
                end
                else
                begin
                    idx_next   = CNT_W'(rem_reg);
                    state_next = ST_VLOAD;
                end
            end

            ST_VLOAD:
            begin
                rem_next  = '0;
                dvs_next  = DVS_W'(p_reg);
                iter_next = ITER_W'(DIV_W);
                if (mode_reg == MODE_SINE)
                begin
                    quo_next   = DIV_W'({idx_reg, {(SINE_BITS+2){1'b0}}});
                    state_next = ST_VDIV;
                end
                else if (idx_reg == '0)
                begin
                    val_next   = '0;
                    state_next = ST_PROD;
                end
                else
                begin
                    quo_next   = tri_prod;
                    state_next = ST_VDIV;
                end
            end

            ST_VDIV:
            begin
                if (div_busy)
                begin
                    quo_next  = quo_step;
                    rem_next  = rem_step;
                    iter_next = iter_reg - ITER_W'(1);
                end
                else
                begin
                    val_next   = (mode_reg == MODE_SINE) ? sine_val : tri_val;
                    state_next = ST_PROD;
                end
            end

            ST_PROD:
            begin
                quo_next   = {scale_prod, {(DIV_W-SCALE_W){1'b0}}};
                rem_next   = '0;
                dvs_next   = DVS_W'(PERMILLE_FULL);
                iter_next  = ITER_W'(SCALE_W);
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                if (div_busy)
                begin
                    quo_next  = quo_step;
                    rem_next  = rem_step;
                    iter_next = iter_reg - ITER_W'(1);
                end
                else
                begin
                    wave_duty_next  = scaled_duty;
                    wave_valid_next = 1'b1;
                    step_next       = (idx_inc == {1'b0, p_reg}) ? '0 : idx_inc[CNT_W-1:0];
                    pend_en_next    = 1'b1;
                    pend_duty_next  = scaled_duty;
                    state_next      = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_en_next    = pend_en_reg;
                    m_duty_next  = pend_duty_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OFF;
            min_reg        <= '0;
            max_reg        <= PERMILLE_FULL;
            on_reg         <= 16'd1;
            off_reg        <= 16'd1;
            period_reg     <= 16'd1000;
            start_reg      <= '0;
            step_reg       <= '0;
            phase_on_reg   <= 1'b1;
            blink_cnt_reg  <= '0;
            wave_valid_reg <= 1'b0;
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            on_reg         <= on_next;
            off_reg        <= off_next;
            period_reg     <= period_next;
            start_reg      <= start_next;
            step_reg       <= step_next;
            phase_on_reg   <= phase_on_next;
            blink_cnt_reg  <= blink_cnt_next;
            wave_valid_reg <= wave_valid_next;
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_duty_reg <= wave_duty_next;
        p_reg         <= p_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        iter_reg      <= iter_next;
        pend_en_reg   <= pend_en_next;
        pend_duty_reg <= pend_duty_next;
        m_en_reg      <= m_en_next;
        m_duty_reg    <= m_duty_next;
    end

    // A new result only ever comes out of the final stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared without passing the final stage");

    // The partial remainder stays below the divisor while a division runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD || state_reg == ST_VDIV || state_reg == ST_SCALE)
        |-> (rem_reg < dvs_reg))
        else $error("divider remainder reached the divisor");

    // Finishing a wave tick leaves the step index inside the period.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE && !div_busy) |=> (step_reg < p_reg))
        else $error("step index left the period");

    // A held wave duty never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        wave_valid_reg |-> (wave_duty_reg <= PERMILLE_FULL))
        else $error("wave duty above full scale");

endmodule

[sim/led_dim_waveform_generator_tb.sv]
// Self-checking testbench for the LED dimming waveform generator, with a built-in predictor.
module led_dim_waveform_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ldwg_pkg::*;

    typedef struct packed {
        logic                  en;
        logic [PERMILLE_W-1:0] duty;
    } led_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic              tick_backlog [$];
    led_result_t       pending_results [$];
    int                fail_count = 0;
    int                src_gap = 0;
    int                sink_gap = 0;
    int                hold_cnt = 0;
    bit                hold_req = 1'b0;
    bit                idle_on = 1'b1;

    logic [2:0]        cfg_mode;
    logic [9:0]        cfg_min;
    logic [9:0]        cfg_max;
    logic [15:0]       cfg_on;
    logic [15:0]       cfg_off;
    logic [15:0]       cfg_period;
    logic [15:0]       cfg_start;
    logic [15:0]       step_idx;
    logic [15:0]       blink_cnt;
    logic              blink_on;
    logic              wave_ok;
    logic [9:0]        wave_duty;
    int unsigned       sine_q16 [SINE_POINTS+1];

    led_dim_waveform_generator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void fill_sine_q16();
        longint unsigned t;
        longint unsigned t2;
        longint unsigned c;
        longint unsigned s;
        int              k;
        for (k = 0; k <= SINE_POINTS; k++)
        begin
            t  = (longint'(k) << 30) / SINE_POINTS;
            t2 = (t * t) >> 30;
            c  = 64'd172273;
            c  = 64'd5026995 - ((t2 * c) >> 30);
            c  = 64'd85569306 - ((t2 * c) >> 30);
            c  = 64'd693598668 - ((t2 * c) >> 30);
            c  = 64'd1686629713 - ((t2 * c) >> 30);
            s  = (t * c) >> 30;
            if (s > (64'd1 << 30))
            begin
                s = 64'd1 << 30;
            end
            sine_q16[k] = int'((s * 64'd500) >> 14);
        end
    endfunction

    function automatic int unsigned period_eff();
        return (cfg_period == 16'd0) ? 1 : int'(cfg_period);
    endfunction

    function automatic void restart_wave();
        step_idx  = (cfg_start < period_eff()) ? cfg_start : 16'd0;
        blink_on  = 1'b1;
        blink_cnt = 16'd0;
        wave_ok   = 1'b0;
    endfunction

    function automatic void model_config(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_MODE:
            begin
                if (val[2:0] != cfg_mode)
                begin
                    restart_wave();
                end
                cfg_mode = val[2:0];
            end
            REG_MIN:       cfg_min = val[9:0];
            REG_MAX:       cfg_max = val[9:0];
            REG_BLINK_ON:  cfg_on = val;
            REG_BLINK_OFF: cfg_off = val;
            REG_PERIOD:    cfg_period = val;
            REG_START:
            begin
                cfg_start = val;
                if (val < period_eff())
                begin
                    step_idx = val;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned sine_at(int unsigned i, int unsigned p);
        longint unsigned q;
        int unsigned     quad;
        int unsigned     r;
        int unsigned     t;
        int unsigned     v;
        q    = (longint'(i) * 4 * SINE_POINTS) / p;
        quad = int'(q / SINE_POINTS) & 3;
        r    = int'(q % SINE_POINTS);
        t    = quad[0] ? sine_q16[SINE_POINTS - r] : sine_q16[r];
        v    = quad[1] ? (500 << 16) - t : (500 << 16) + t;
        return (v + 65535) >> 16;
    endfunction

    function automatic int unsigned ramp_at(int unsigned i, int unsigned p);
        int unsigned v;
        if (i == 0)
        begin
            v = 0;
        end
        else if (i < (p >> 1))
        begin
            v = (2000 * i) / p;
        end
        else
        begin
            v = (2000 * (p - i)) / p;
        end
        return (v > 1000) ? 1000 : v;
    endfunction

    function automatic led_result_t led_duty_after(logic tick);
        led_result_t r;
        int unsigned mx;
        int unsigned mn;
        int unsigned p;
        int unsigned i;
        int unsigned v;
        int unsigned len;
        mx = (cfg_max > 10'd1000) ? 1000 : cfg_max;
        mn = (cfg_min > mx) ? mx : cfg_min;
        r  = '0;
        case (cfg_mode)
            MODE_ON:
            begin
                r.en   = 1'b1;
                r.duty = mx[9:0];
            end
            MODE_BLINK:
            begin
                if (cfg_on == 16'd0)
                begin
                    r.en = 1'b0;
                end
                else if (cfg_off == 16'd0)
                begin
                    r.en = 1'b1;
                end
                else
                begin
                    if (tick)
                    begin
                        len       = blink_on ? cfg_on : cfg_off;
                        blink_cnt = blink_cnt + 16'd1;
                        if (blink_cnt >= len)
                        begin
                            blink_on  = !blink_on;
                            blink_cnt = 16'd0;
                        end
                    end
                    r.en = blink_on;
                end
                r.duty = r.en ? mx[9:0] : 10'd0;
            end
            MODE_SINE, MODE_TRIANGLE:
            begin
                if (tick)
                begin
                    p         = period_eff();
                    i         = step_idx % p;
                    v         = (cfg_mode == MODE_SINE) ? sine_at(i, p) : ramp_at(i, p);
                    wave_duty = 10'(mn + ((mx - mn) * v) / 1000);
                    wave_ok   = 1'b1;
                    step_idx  = 16'((i + 1) % p);
                end
                r.en   = 1'b1;
                r.duty = wave_ok ? wave_duty : mx[9:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sender side: one tick per transaction, with random gaps between them.
    always @(posedge clk)
    begin
        bit took;
        took = s_axis_tvalid && s_axis_tready;
        if (took)
        begin
            pending_results.push_back(led_duty_after(s_axis_tdata[0]));
        end
        if (!s_axis_tvalid || took)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (tick_backlog.size() != 0)
            begin
                s_axis_tdata  <= {7'd0, tick_backlog.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    src_gap = $urandom_range(1, 4);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side: compares each result transaction and drives backpressure.
    always @(posedge clk)
    begin
        led_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: pwm_enable %0d duty_permille %0d",
                       m_axis_tdata[0], m_axis_tdata[10:1]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.en)
                begin
                    $error("pwm_enable: expected %0d, got %0d", want.en, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[10:1] !== want.duty)
                begin
                    $error("duty_permille: expected %0d, got %0d",
                           want.duty, m_axis_tdata[10:1]);
                    fail_count++;
                end
            end
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 300;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_config(idx, val);
    endtask

    task automatic drain(int extra);
        do @(posedge clk);
        while (tick_backlog.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic push_ticks(logic [15:0] pattern, int n);
        for (int k = 0; k < n; k++)
        begin
            tick_backlog.push_back(pattern[k]);
        end
    endtask

    function automatic logic [15:0] reg_value(logic [2:0] idx);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (idx)
            REG_MODE:
            begin
                case (r)
                    0:       return 16'(MODE_OFF);
                    1:       return 16'(MODE_ON);
                    2, 3:    return 16'(MODE_BLINK);
                    4, 5, 6: return 16'(MODE_SINE);
                    7, 8:    return 16'(MODE_TRIANGLE);
                    default: return 16'(MODE_TRIANGLE) + 16'($urandom_range(1, 3));
                endcase
            end
            REG_MIN, REG_MAX:
            begin
                case (r)
                    0:       return 16'd0;
                    1:       return 16'd1000;
                    2:       return 16'd1023;
                    default: return 16'($urandom_range(0, 1000));
                endcase
            end
            REG_BLINK_ON, REG_BLINK_OFF:
            begin
                case (r)
                    0:       return 16'd0;
                    1:       return 16'hFFFF;
                    2:       return 16'($urandom_range(0, 65535));
                    default: return 16'($urandom_range(1, 6));
                endcase
            end
            REG_PERIOD:
            begin
                case (r)
                    0:       return 16'd0;
                    1:       return 16'hFFFF;
                    2:       return 16'd1;
                    3:       return 16'($urandom_range(0, 65535));
                    default: return 16'($urandom_range(1, 40));
                endcase
            end
            default:
            begin
                case (r)
                    0:       return 16'd0;
                    1:       return 16'hFFFF;
                    2:       return 16'($urandom_range(0, 65535));
                    default: return 16'($urandom_range(0, 40));
                endcase
            end
        endcase
    endfunction

    initial
    begin
        logic [2:0] order [7];
        logic [2:0] swap;
        int         j;
        int         n;
        int         phase;
        int         ticks_queued;

        cfg_mode   = MODE_OFF;
        cfg_min    = 10'd0;
        cfg_max    = 10'd1000;
        cfg_on     = 16'd1;
        cfg_off    = 16'd1;
        cfg_period = 16'd1000;
        cfg_start  = 16'd0;
        wave_duty  = 10'd0;
        fill_sine_q16();
        restart_wave();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: the block is off.
        push_ticks(16'b01, 2);
        drain(80);

        // On mode with a maximum above full scale.
        write_reg(REG_MAX, 16'd1023);
        write_reg(REG_MODE, 16'(MODE_ON));
        push_ticks(16'b01, 2);
        drain(80);

        // Blink with a zero on-time, then a zero off-time, then regular phases.
        write_reg(REG_MAX, 16'd1000);
        write_reg(REG_BLINK_ON, 16'd0);
        write_reg(REG_MODE, 16'(MODE_BLINK));
        push_ticks(16'b1, 1);
        drain(80);
        write_reg(REG_BLINK_ON, 16'd3);
        write_reg(REG_BLINK_OFF, 16'd0);
        push_ticks(16'b1, 1);
        drain(80);
        write_reg(REG_BLINK_OFF, 16'd1);
        push_ticks(16'b11011, 5);
        drain(80);

        // Sine with a zero period and the minimum above the maximum; no tick first.
        write_reg(REG_MIN, 16'd1000);
        write_reg(REG_MAX, 16'd400);
        write_reg(REG_PERIOD, 16'd0);
        write_reg(REG_MODE, 16'(MODE_SINE));
        push_ticks(16'b110, 3);
        drain(80);

        // Triangle over an odd period, where the falling edge overshoots.
        write_reg(REG_MIN, 16'd0);
        write_reg(REG_MAX, 16'd1000);
        write_reg(REG_PERIOD, 16'd7);
        write_reg(REG_MODE, 16'(MODE_TRIANGLE));
        push_ticks(16'h7F, 7);
        drain(80);

        // Sine from a start index, then the period lowered below the index.
        write_reg(REG_PERIOD, 16'd1000);
        write_reg(REG_MODE, 16'(MODE_SINE));
        write_reg(REG_START, 16'd900);
        push_ticks(16'b11, 2);
        drain(80);
        write_reg(REG_PERIOD, 16'd5);
        push_ticks(16'b11, 2);
        drain(80);

        // Unused mode codes.
        for (int m = 1; m <= 3; m++)
        begin
            write_reg(REG_MODE, 16'(MODE_TRIANGLE) + 16'(m));
            push_ticks(16'b1, 1);
            drain(80);
        end

        phase        = 0;
        ticks_queued = 0;
        while (ticks_queued < 1500)
        begin
            idle_on = (ticks_queued < 1250) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 1)
            begin
                for (int k = 0; k < 7; k++)
                begin
                    order[k] = 3'(k);
                end
                for (int k = 6; k > 0; k--)
                begin
                    j        = $urandom_range(0, k);
                    swap     = order[k];
                    order[k] = order[j];
                    order[j] = swap;
                end
                for (int k = 0; k < 7; k++)
                begin
                    write_reg(order[k], reg_value(order[k]));
                end
            end
            else
            begin
                for (int k = 0; k < 7; k++)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        write_reg(3'(k), reg_value(3'(k)));
                    end
                end
            end
            n = (phase == 3) ? 40 : $urandom_range(10, 60);
            for (int k = 0; k < n; k++)
            begin
                tick_backlog.push_back($urandom_range(0, 99) < 85);
            end
            ticks_queued += n;
            if (phase == 3)
            begin
                hold_req = 1'b1;
            end
            phase++;
            drain(80);
        end

        drain(100);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
